>>> sv/pba_pkg.sv
// Shared constants and codes for the page bitmap allocator.
// No dependencies.
package pba_pkg;

  localparam int unsigned FRAMES      = 4096;
  localparam int unsigned CACHE_SLOTS = 32;
  localparam int unsigned FRAME_W     = 12;
  localparam int unsigned COUNT_W     = 13;
  localparam int unsigned WORDS       = FRAMES / 8;
  localparam int unsigned WADDR_W     = $clog2(WORDS);
  localparam int unsigned SLOT_W      = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_FREE    = 2'd1;
  localparam logic [1:0] MODE_RESERVE = 2'd2;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NOMEM   = 2'd1;
  localparam logic [1:0] STATUS_REFUSED = 2'd2;

  localparam logic [COUNT_W-1:0] FRAMES_C = COUNT_W'(FRAMES);

endpackage

>>> sv/page_bitmap_allocator.sv
// Page-frame allocator: used-bit map in a 512 x 8 RAM plus a cache of freed frames.
// Depends on pba_pkg.
//
//  channel | direction | handshake           | word
//  in      | input     | in_valid_i/in_stall_o   | mode_i, frame_i, page_count_i
//  out     | output    | out_valid_o/out_stall_i | result_frame_o, status_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o | limit_frames_i
//
// One request at a time. Each 8-frame map word is walked as a RAM read, then
// an evaluate or write-back step; a cached single frame skips the scan and
// only marks its own map word.
// After reset an init pass sets every map word to all used; in_stall_o is high.
// The next word is taken while a result waits under out_stall_i.
module page_bitmap_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   mode_i,
  input  logic [pba_pkg::FRAME_W-1:0]  frame_i,
  input  logic [pba_pkg::COUNT_W-1:0]  page_count_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [pba_pkg::FRAME_W-1:0]  result_frame_o,
  output logic [1:0]                   status_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pba_pkg::COUNT_W-1:0]  limit_frames_i
);

  localparam int unsigned FW = pba_pkg::FRAME_W;
  localparam int unsigned CW = pba_pkg::COUNT_W;
  localparam int unsigned AW = pba_pkg::WADDR_W;
  localparam int unsigned SW = pba_pkg::SLOT_W;
  localparam int unsigned NS = pba_pkg::CACHE_SLOTS;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_CACHE_RD, ST_SCAN_RD, ST_SCAN_EV,
    ST_CHK_RD, ST_CHK_EV, ST_MARK_RD, ST_MARK_WR, ST_FIN
  } state_e;

  state_e            state_q, state_d;
  logic [AW-1:0]     init_q, init_d;
  logic [CW-1:0]     limit_q, limit_d;
  logic [FW-1:0]     ss_q, ss_d;
  logic [NS-1:0]     full_q, full_d;
  logic              out_valid_q, out_valid_d;
  logic              pass_q, pass_d;

  logic [CW-1:0]     cnt_q, cnt_d, lim_q, lim_d;
  logic [FW-1:0]     first_q, first_d, res_q, res_d, out_res_q, out_res_d;
  logic [CW-1:0]     end_q, end_d, lo_q, lo_d, cap_q, cap_d, run_q, run_d;
  logic [AW:0]       word_q, word_d;
  logic              set_q, set_d;
  logic [1:0]        stat_q, stat_d, out_stat_q, out_stat_d;
  logic [SW-1:0]     cidx_q, cidx_d;

  logic [7:0]        map_mem [pba_pkg::WORDS];
  logic [7:0]        map_rd_q;
  logic              map_we, map_re;
  logic [AW-1:0]     map_addr;
  logic [7:0]        map_wdata;

  logic [FW-1:0]     cache_mem [NS];
  logic [FW-1:0]     cache_rd_q;
  logic              cache_we, cache_re;
  logic [SW-1:0]     cache_waddr;

  logic [CW-1:0]     lim_now, base, next_base;
  logic [SW-1:0]     full_idx, empty_idx;
  logic              any_full, any_empty;
  logic [7:0]        mask;
  logic [CW-1:0]     run_v, s_v, f_v, sum_v;
  logic [CW:0]       ext_v;
  logic              hit_v;

  function automatic logic [CW-1:0] min13(logic [CW-1:0] a, logic [CW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  assign in_stall_o     = (state_q != ST_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign result_frame_o = out_res_q;
  assign status_o       = out_stat_q;

  assign lim_now   = min13(limit_q, pba_pkg::FRAMES_C);
  assign base      = {word_q[CW-4:0], 3'b000};
  assign next_base = base + CW'(8);

  always_comb begin
    full_idx  = '0;
    empty_idx = '0;
    for (int k = NS - 1; k >= 0; k--) begin
      if (full_q[k]) full_idx = SW'(k);
      if (!full_q[k]) empty_idx = SW'(k);
    end
    any_full  = |full_q;
    any_empty = ~&full_q;
  end

  // run mask for the current word
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mask[b] = ((base + CW'(b)) >= {1'b0, first_q}) && ((base + CW'(b)) < end_q);
    end
  end

  // free-run search across one word, up to eight chained steps
  always_comb begin
    run_v = run_q;
    hit_v = 1'b0;
    s_v   = '0;
    for (int b = 0; b < 8; b++) begin
      f_v = base + CW'(b);
      if (!hit_v && f_v >= lo_q && f_v < cap_q) begin
        if (map_rd_q[b]) begin
          run_v = '0;
        end else begin
          run_v = run_v + CW'(1);
          if (run_v == cnt_q) begin
            hit_v = 1'b1;
            s_v   = f_v + CW'(1) - cnt_q;
          end
        end
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    init_d      = init_q;
    limit_d     = limit_q;
    ss_d        = ss_q;
    full_d      = full_q;
    out_valid_d = out_valid_q;
    pass_d      = pass_q;
    cnt_d       = cnt_q;
    lim_d       = lim_q;
    first_d     = first_q;
    res_d       = res_q;
    out_res_d   = out_res_q;
    out_stat_d  = out_stat_q;
    end_d       = end_q;
    lo_d        = lo_q;
    cap_d       = cap_q;
    run_d       = run_q;
    word_d      = word_q;
    set_d       = set_q;
    stat_d      = stat_q;
    cidx_d      = cidx_q;
    map_we      = 1'b0;
    map_re      = 1'b0;
    map_addr    = word_q[AW-1:0];
    map_wdata   = set_q ? (map_rd_q | mask) : (map_rd_q & ~mask);
    cache_we    = 1'b0;
    cache_re    = 1'b0;
    cache_waddr = empty_idx;
    sum_v       = '0;
    ext_v       = '0;

    if (cfg_valid_i) limit_d = limit_frames_i;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    case (state_q)
      ST_INIT: begin
        map_we    = 1'b1;
        map_addr  = init_q;
        map_wdata = 8'hff;
        init_d    = init_q + AW'(1);
        if (&init_q) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cnt_d  = page_count_i;
          lim_d  = lim_now;
          res_d  = '0;
          stat_d = pba_pkg::STATUS_OK;
          case (mode_i)
            pba_pkg::MODE_ALLOC: begin
              if (page_count_i == CW'(1) && any_full) begin
                cidx_d   = full_idx;
                cache_re = 1'b1;
                state_d  = ST_CACHE_RD;
              end else if (page_count_i == '0 || page_count_i > lim_now) begin
                stat_d  = pba_pkg::STATUS_NOMEM;
                state_d = ST_FIN;
              end else if ({1'b0, ss_q} < lim_now) begin
                pass_d  = 1'b0;
                lo_d    = {1'b0, ss_q};
                cap_d   = lim_now;
                word_d  = {1'b0, ss_q[FW-1:3]};
                run_d   = '0;
                state_d = ST_SCAN_RD;
              end else if (ss_q != '0) begin
                pass_d  = 1'b1;
                lo_d    = '0;
                cap_d   = min13({1'b0, ss_q} - CW'(1) + page_count_i, lim_now);
                word_d  = '0;
                run_d   = '0;
                state_d = ST_SCAN_RD;
              end else begin
                stat_d  = pba_pkg::STATUS_NOMEM;
                state_d = ST_FIN;
              end
            end
            pba_pkg::MODE_FREE: begin
              if (page_count_i == CW'(1) && frame_i != '0 && any_empty) begin
                cache_we = 1'b1;
                full_d[empty_idx] = 1'b1;
              end
              ext_v   = {2'b00, frame_i} + {1'b0, page_count_i};
              first_d = frame_i;
              end_d   = (ext_v > (CW + 1)'(pba_pkg::FRAMES)) ? pba_pkg::FRAMES_C
                                                             : ext_v[CW-1:0];
              set_d   = 1'b0;
              word_d  = {1'b0, frame_i[FW-1:3]};
              state_d = ST_MARK_RD;
            end
            pba_pkg::MODE_RESERVE: begin
              ext_v   = {2'b00, frame_i} + {1'b0, page_count_i};
              first_d = frame_i;
              end_d   = ext_v[CW-1:0];
              word_d  = {1'b0, frame_i[FW-1:3]};
              if (page_count_i == '0) begin
                state_d = ST_FIN;
              end else if (ext_v > (CW + 1)'(pba_pkg::FRAMES)) begin
                stat_d  = pba_pkg::STATUS_REFUSED;
                state_d = ST_FIN;
              end else begin
                state_d = ST_CHK_RD;
              end
            end
            default: state_d = ST_FIN;
          endcase
        end
      end
      ST_CACHE_RD: begin
        full_d[cidx_q] = 1'b0;
        sum_v   = {1'b0, cache_rd_q} + CW'(1);
        first_d = cache_rd_q;
        end_d   = sum_v;
        res_d   = cache_rd_q;
        ss_d    = sum_v[CW-1] ? '0 : sum_v[FW-1:0];
        set_d   = 1'b1;
        word_d  = {1'b0, cache_rd_q[FW-1:3]};
        state_d = ST_MARK_RD;
      end
      ST_SCAN_RD: begin
        map_re  = 1'b1;
        state_d = ST_SCAN_EV;
      end
      ST_SCAN_EV: begin
        run_d = run_v;
        if (hit_v) begin
          sum_v   = s_v + cnt_q;
          first_d = s_v[FW-1:0];
          end_d   = sum_v;
          res_d   = s_v[FW-1:0];
          ss_d    = sum_v[CW-1] ? '0 : sum_v[FW-1:0];
          set_d   = 1'b1;
          word_d  = {1'b0, s_v[FW-1:3]};
          state_d = ST_MARK_RD;
        end else if (next_base >= cap_q) begin
          if (!pass_q && ss_q != '0) begin
            pass_d  = 1'b1;
            lo_d    = '0;
            cap_d   = min13({1'b0, ss_q} - CW'(1) + cnt_q, lim_q);
            word_d  = '0;
            run_d   = '0;
            state_d = ST_SCAN_RD;
          end else begin
            stat_d  = pba_pkg::STATUS_NOMEM;
            state_d = ST_FIN;
          end
        end else begin
          word_d  = word_q + (AW + 1)'(1);
          state_d = ST_SCAN_RD;
        end
      end
      ST_CHK_RD: begin
        map_re  = 1'b1;
        state_d = ST_CHK_EV;
      end
      ST_CHK_EV: begin
        if (|(map_rd_q & mask)) begin
          stat_d  = pba_pkg::STATUS_REFUSED;
          state_d = ST_FIN;
        end else if (next_base >= end_q) begin
          word_d  = {1'b0, first_q[FW-1:3]};
          set_d   = 1'b1;
          state_d = ST_MARK_RD;
        end else begin
          word_d  = word_q + (AW + 1)'(1);
          state_d = ST_CHK_RD;
        end
      end
      ST_MARK_RD: begin
        if (base >= end_q) begin
          state_d = ST_FIN;
        end else begin
          map_re  = 1'b1;
          state_d = ST_MARK_WR;
        end
      end
      ST_MARK_WR: begin
        map_we  = 1'b1;
        word_d  = word_q + (AW + 1)'(1);
        state_d = ST_MARK_RD;
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          out_stat_d  = stat_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      init_q      <= '0;
      limit_q     <= pba_pkg::FRAMES_C;
      ss_q        <= '0;
      full_q      <= '0;
      out_valid_q <= 1'b0;
      pass_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      limit_q     <= limit_d;
      ss_q        <= ss_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
      pass_q      <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    lim_q      <= lim_d;
    first_q    <= first_d;
    res_q      <= res_d;
    out_res_q  <= out_res_d;
    out_stat_q <= out_stat_d;
    end_q      <= end_d;
    lo_q       <= lo_d;
    cap_q      <= cap_d;
    run_q      <= run_d;
    word_q     <= word_d;
    set_q      <= set_d;
    stat_q     <= stat_d;
    cidx_q     <= cidx_d;
  end

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_addr] <= map_wdata;
    if (map_re) map_rd_q <= map_mem[map_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cache_we) cache_mem[cache_waddr] <= frame_i;
    if (cache_re) cache_rd_q <= cache_mem[full_idx];
  end

endmodule

>>> sv/pba_checker.sv
// Port-level checks for page_bitmap_allocator, bound into that module.
// Depends on pba_pkg.
module pba_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [pba_pkg::FRAME_W-1:0] result_frame_o,
  input logic [1:0]                  status_o
);

  // one request at a time: busy right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a request is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_frame_o) && $stable(status_o))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= pba_pkg::STATUS_REFUSED)
    else $error("undefined status code");

  a_frame_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_frame_o != '0 |-> status_o == pba_pkg::STATUS_OK)
    else $error("frame number returned with failing status");

endmodule

bind page_bitmap_allocator pba_checker u_pba_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .result_frame_o (result_frame_o),
  .status_o       (status_o)
);
